[src/rvrec_pkg.sv]
package rvrec_pkg;

  // major opcodes of rv32im
  localparam logic [6:0] OPC_LOAD   = 7'd3;
  localparam logic [6:0] OPC_OPIMM  = 7'd19;
  localparam logic [6:0] OPC_AUIPC  = 7'd23;
  localparam logic [6:0] OPC_STORE  = 7'd35;
  localparam logic [6:0] OPC_REG    = 7'd51;
  localparam logic [6:0] OPC_LUI    = 7'd55;
  localparam logic [6:0] OPC_BRANCH = 7'd99;
  localparam logic [6:0] OPC_JALR   = 7'd103;
  localparam logic [6:0] OPC_JAL    = 7'd111;
  localparam logic [6:0] OPC_SYSTEM = 7'd115;

  // funct7 values of the register-register group
  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_MULDIV = 7'd1;
  localparam logic [6:0] F7_ALT = 7'd32;

  // dense operation numbers
  localparam logic [5:0] OP_LB     = 6'd0;
  localparam logic [5:0] OP_LH     = 6'd1;
  localparam logic [5:0] OP_LW     = 6'd2;
  localparam logic [5:0] OP_LBU    = 6'd3;
  localparam logic [5:0] OP_LHU    = 6'd4;
  localparam logic [5:0] OP_ADDI   = 6'd5;
  localparam logic [5:0] OP_SLLI   = 6'd6;
  localparam logic [5:0] OP_SLTI   = 6'd7;
  localparam logic [5:0] OP_SLTIU  = 6'd8;
  localparam logic [5:0] OP_XORI   = 6'd9;
  localparam logic [5:0] OP_SRLI   = 6'd10;
  localparam logic [5:0] OP_SRAI   = 6'd11;
  localparam logic [5:0] OP_ORI    = 6'd12;
  localparam logic [5:0] OP_ANDI   = 6'd13;
  localparam logic [5:0] OP_SB     = 6'd14;
  localparam logic [5:0] OP_SH     = 6'd15;
  localparam logic [5:0] OP_SW     = 6'd16;
  localparam logic [5:0] OP_BEQ    = 6'd17;
  localparam logic [5:0] OP_BNE    = 6'd18;
  localparam logic [5:0] OP_BLT    = 6'd19;
  localparam logic [5:0] OP_BGE    = 6'd20;
  localparam logic [5:0] OP_BLTU   = 6'd21;
  localparam logic [5:0] OP_BGEU   = 6'd22;
  localparam logic [5:0] OP_JALR   = 6'd23;
  localparam logic [5:0] OP_SYS    = 6'd24;
  localparam logic [5:0] OP_ADD    = 6'd25;
  localparam logic [5:0] OP_SUB    = 6'd26;
  localparam logic [5:0] OP_SLL    = 6'd27;
  localparam logic [5:0] OP_SLT    = 6'd28;
  localparam logic [5:0] OP_SLTU   = 6'd29;
  localparam logic [5:0] OP_XOR    = 6'd30;
  localparam logic [5:0] OP_SRL    = 6'd31;
  localparam logic [5:0] OP_SRA    = 6'd32;
  localparam logic [5:0] OP_OR     = 6'd33;
  localparam logic [5:0] OP_AND    = 6'd34;
  localparam logic [5:0] OP_MUL    = 6'd35;
  localparam logic [5:0] OP_MULH   = 6'd36;
  localparam logic [5:0] OP_MULHSU = 6'd37;
  localparam logic [5:0] OP_MULHU  = 6'd38;
  localparam logic [5:0] OP_DIV    = 6'd39;
  localparam logic [5:0] OP_DIVU   = 6'd40;
  localparam logic [5:0] OP_REM    = 6'd41;
  localparam logic [5:0] OP_REMU   = 6'd42;
  localparam logic [5:0] OP_UPC    = 6'd43;
  localparam logic [5:0] OP_LUI    = 6'd44;
  localparam logic [5:0] OP_JAL    = 6'd45;

  typedef enum logic [3:0] {
    FMT_LOAD,
    FMT_OPIMM,
    FMT_STORE,
    FMT_BRANCH,
    FMT_JALR,
    FMT_SYSTEM,
    FMT_REG,
    FMT_AUIPC,
    FMT_LUI,
    FMT_JAL,
    FMT_BAD
  } fmt_t;

  // decode stage -> form stage
  typedef struct packed {
    fmt_t        fmt;
    logic [31:0] word;
    logic        eob;
  } dec_t;

  // form stage -> pack stage
  typedef struct packed {
    logic [5:0]  op;
    logic [31:0] body;
    logic        bad;
    logic        eob;
  } form_t;

  function automatic logic [5:0] op_number(fmt_t fmt, logic [2:0] f3, logic [6:0] f7);
    logic [5:0] op;
    op = OP_LB;
    case (fmt)
      FMT_LOAD: begin
        case (f3)
          3'd0: op = OP_LB;
          3'd1: op = OP_LH;
          3'd2: op = OP_LW;
          3'd4: op = OP_LBU;
          3'd5: op = OP_LHU;
          default: op = OP_LB;
        endcase
      end
      FMT_OPIMM: begin
        case (f3)
          3'd0: op = OP_ADDI;
          3'd1: op = OP_SLLI;
          3'd2: op = OP_SLTI;
          3'd3: op = OP_SLTIU;
          3'd4: op = OP_XORI;
          3'd5: op = f7[5] ? OP_SRAI : OP_SRLI;
          3'd6: op = OP_ORI;
          default: op = OP_ANDI;
        endcase
      end
      FMT_STORE: begin
        case (f3)
          3'd0: op = OP_SB;
          3'd1: op = OP_SH;
          3'd2: op = OP_SW;
          default: op = OP_LB;
        endcase
      end
      FMT_BRANCH: begin
        case (f3)
          3'd0: op = OP_BEQ;
          3'd1: op = OP_BNE;
          3'd4: op = OP_BLT;
          3'd5: op = OP_BGE;
          3'd6: op = OP_BLTU;
          3'd7: op = OP_BGEU;
          default: op = OP_LB;
        endcase
      end
      FMT_JALR:   op = OP_JALR;
      FMT_SYSTEM: op = OP_SYS;
      FMT_REG: begin
        case (f7)
          F7_BASE: begin
            case (f3)
              3'd0: op = OP_ADD;
              3'd1: op = OP_SLL;
              3'd2: op = OP_SLT;
              3'd3: op = OP_SLTU;
              3'd4: op = OP_XOR;
              3'd5: op = OP_SRL;
              3'd6: op = OP_OR;
              default: op = OP_AND;
            endcase
          end
          F7_ALT: begin
            case (f3)
              3'd0: op = OP_SUB;
              3'd5: op = OP_SRA;
              default: op = OP_LB;
            endcase
          end
          F7_MULDIV: begin
            case (f3)
              3'd0: op = OP_MUL;
              3'd1: op = OP_MULH;
              3'd2: op = OP_MULHSU;
              3'd3: op = OP_MULHU;
              3'd4: op = OP_DIV;
              3'd5: op = OP_DIVU;
              3'd6: op = OP_REM;
              default: op = OP_REMU;
            endcase
          end
          default: op = OP_LB;
        endcase
      end
      FMT_AUIPC: op = OP_UPC;
      FMT_LUI:   op = OP_LUI;
      FMT_JAL:   op = OP_JAL;
      default:   op = OP_LB;
    endcase
    return op;
  endfunction

endpackage

[src/rvrec_ifs.sv]
interface rvrec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic        end_of_block;

  modport source (output valid, output instr_word, output end_of_block, input ready);
  modport sink (input valid, input instr_word, input end_of_block, output ready);
endinterface

interface rvrec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] vm_word;
  logic        invalid_opcode;
  logic        end_of_block_out;

  modport source (output valid, output vm_word, output invalid_opcode,
                  output end_of_block_out, input ready);
  modport sink (input valid, input vm_word, input invalid_opcode,
                input end_of_block_out, output ready);
endinterface

[src/rvrec_decode.sv]
module rvrec_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_word,
  input  logic               in_eob,
  output logic               out_valid,
  input  logic               out_ready,
  output rvrec_pkg::dec_t    out_data
);
  import rvrec_pkg::*;

  logic valid_r;
  dec_t data_r;
  dec_t data_nxt;

  assign in_ready = !valid_r || out_ready;

  // major opcode class
  always_comb begin
    data_nxt.word = in_word;
    data_nxt.eob  = in_eob;
    case (in_word[6:0])
      OPC_LOAD:   data_nxt.fmt = FMT_LOAD;
      OPC_OPIMM:  data_nxt.fmt = FMT_OPIMM;
      OPC_AUIPC:  data_nxt.fmt = FMT_AUIPC;
      OPC_STORE:  data_nxt.fmt = FMT_STORE;
      OPC_REG:    data_nxt.fmt = FMT_REG;
      OPC_LUI:    data_nxt.fmt = FMT_LUI;
      OPC_BRANCH: data_nxt.fmt = FMT_BRANCH;
      OPC_JALR:   data_nxt.fmt = FMT_JALR;
      OPC_JAL:    data_nxt.fmt = FMT_JAL;
      OPC_SYSTEM: data_nxt.fmt = FMT_SYSTEM;
      default:    data_nxt.fmt = FMT_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

[src/rvrec_form.sv]
module rvrec_form (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rvrec_pkg::dec_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rvrec_pkg::form_t   out_data
);
  import rvrec_pkg::*;

  logic        valid_r;
  form_t       data_r;
  form_t       data_nxt;
  logic [31:0] w;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [11:0] s_imm;
  logic [12:0] b_imm;
  logic [20:0] j_imm;

  assign in_ready = !valid_r || out_ready;

  assign w     = in_data.word;
  assign rd    = w[11:7];
  assign rs1   = w[19:15];
  assign rs2   = w[24:20];
  assign s_imm = {w[31:25], w[11:7]};
  assign b_imm = {w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign j_imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};

  always_comb begin
    data_nxt.op  = op_number(in_data.fmt, w[14:12], w[31:25]);
    data_nxt.eob = in_data.eob;
    data_nxt.bad = 1'b0;
    case (in_data.fmt)
      FMT_LOAD, FMT_OPIMM, FMT_JALR:
        data_nxt.body = {{4{w[31]}}, w[31:20], rd, rs1, 6'd0};
      FMT_STORE:
        data_nxt.body = {{4{w[31]}}, s_imm, rs2, rs1, 6'd0};
      FMT_BRANCH:
        data_nxt.body = {{3{w[31]}}, b_imm, rs2, rs1, 6'd0};
      FMT_SYSTEM:
        data_nxt.body = {{4{w[31]}}, w[31:20], 16'd0};
      FMT_REG:
        data_nxt.body = {11'd0, rd, rs2, rs1, 6'd0};
      FMT_AUIPC, FMT_LUI:
        data_nxt.body = {w[31:12], 1'b0, rd, 6'd0};
      FMT_JAL:
        data_nxt.body = {j_imm, rd, 6'd0};
      default: begin
        data_nxt.body = '0;
        data_nxt.bad  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
endmodule

[src/rvrec_pack.sv]
module rvrec_pack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rvrec_pkg::form_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_vm_word,
  output logic               out_invalid,
  output logic               out_eob
);
  import rvrec_pkg::*;

  logic        valid_r;
  logic [31:0] word_r;
  logic [31:0] word_nxt;
  logic        invalid_r;
  logic        eob_r;

  assign in_ready = !valid_r || out_ready;

  // unknown opcodes already carry a zero body and op
  assign word_nxt = in_data.body | {26'd0, in_data.op};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r    <= word_nxt;
      invalid_r <= in_data.bad;
      eob_r     <= in_data.eob;
    end
  end

  assign out_valid   = valid_r;
  assign out_vm_word = word_r;
  assign out_invalid = invalid_r;
  assign out_eob     = eob_r;
endmodule

[src/rv32im_to_vm_instruction_recoder_top.sv]
// an accepted item passes the decode, form and pack registers in that order before its result reaches out_ch
// throughput: one item per cycle while out_ch is not stalled, set by the three-stage decode/form/pack pipeline
// each stage holds its item while the next one is full and stalled, so a stall
//   stops the whole pipe without loss and a new item still enters behind a waiting result
// reset: synchronous, active low; clears the stage valid bits only
module rv32im_to_vm_instruction_recoder_top (
  input  logic               clk,
  input  logic               rst_n,
  rvrec_in_if.sink           in_ch,
  rvrec_out_if.source        out_ch
);
  import rvrec_pkg::*;

  // decode stage: classify the major opcode
  logic  dec_valid;
  logic  dec_ready;
  dec_t  dec_data;

  // form stage: operation number and field placement
  logic  form_valid;
  logic  form_ready;
  form_t form_data;

  rvrec_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word   (in_ch.instr_word),
    .in_eob    (in_ch.end_of_block),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  rvrec_form u_form (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (form_valid),
    .out_ready (form_ready),
    .out_data  (form_data)
  );

  // pack stage doubles as the output register
  rvrec_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (form_valid),
    .in_ready    (form_ready),
    .in_data     (form_data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_vm_word (out_ch.vm_word),
    .out_invalid (out_ch.invalid_opcode),
    .out_eob     (out_ch.end_of_block_out)
  );

`ifndef NO_ASSERTIONS
  // an unknown opcode always yields an all-zero word
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.invalid_opcode |-> out_ch.vm_word == 32'd0)
    else $error("invalid opcode result is not zero");

  // the operation number never leaves the dense range
  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.vm_word[5:0] <= OP_JAL)
    else $error("operation number out of range");

  // input back-pressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without output back-pressure");

  // a stalled result is not replaced while the pipe is full
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |=> $stable(out_ch.vm_word))
    else $error("result changed during a full stall");
`endif

endmodule

[dv/rvrec_recode_checker.sv]
`timescale 1ns / 1ps

module rvrec_recode_checker (
  input  logic  clk,
  input  logic  rst_n,
  rvrec_in_if   in_ch,
  rvrec_out_if  out_ch,
  output int    fail_count,
  output int    results_due
);
  import rvrec_pkg::*;

  typedef struct packed {
    logic [31:0] vm_word;
    logic        invalid_opcode;
    logic        end_of_block;
  } recoded_t;

  // op numbers indexed by funct3, unmatched slots fall back to OP_LB
  logic [5:0] load_ops   [8] = '{OP_LB, OP_LH, OP_LW, OP_LB, OP_LBU, OP_LHU, OP_LB, OP_LB};
  logic [5:0] opimm_ops  [8] = '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU,
                                 OP_XORI, OP_SRLI, OP_ORI, OP_ANDI};
  logic [5:0] store_ops  [8] = '{OP_SB, OP_SH, OP_SW, OP_LB, OP_LB, OP_LB, OP_LB, OP_LB};
  logic [5:0] branch_ops [8] = '{OP_BEQ, OP_BNE, OP_LB, OP_LB,
                                 OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};
  logic [5:0] base_ops   [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU,
                                 OP_XOR, OP_SRL, OP_OR, OP_AND};
  logic [5:0] alt_ops    [8] = '{OP_SUB, OP_LB, OP_LB, OP_LB, OP_LB, OP_SRA, OP_LB, OP_LB};
  logic [5:0] muldiv_ops [8] = '{OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
                                 OP_DIV, OP_DIVU, OP_REM, OP_REMU};

  recoded_t due_q [$];
  int       result_idx;

  function automatic recoded_t recode_instr(logic [31:0] w, logic eob);
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] i_imm, s_imm, b_imm, j_imm;
    logic [5:0]  op;
    recoded_t    r;
    rd  = w[11:7];
    f3  = w[14:12];
    rs1 = w[19:15];
    rs2 = w[24:20];
    f7  = w[31:25];
    i_imm = {{20{w[31]}}, w[31:20]};
    s_imm = {{20{w[31]}}, w[31:25], w[11:7]};
    b_imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    j_imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    r.vm_word        = '0;
    r.invalid_opcode = 1'b0;
    r.end_of_block   = eob;
    case (w[6:0])
      OPC_LOAD:   r.vm_word = {i_imm[15:0], rd, rs1, load_ops[f3]};
      OPC_OPIMM: begin
        op = opimm_ops[f3];
        // shift right: only bit 30 picks the arithmetic form
        if (op == OP_SRLI && w[30]) op = OP_SRAI;
        r.vm_word = {i_imm[15:0], rd, rs1, op};
      end
      OPC_STORE:  r.vm_word = {s_imm[15:0], rs2, rs1, store_ops[f3]};
      OPC_BRANCH: r.vm_word = {b_imm[15:0], rs2, rs1, branch_ops[f3]};
      OPC_JALR:   r.vm_word = {i_imm[15:0], rd, rs1, OP_JALR};
      OPC_SYSTEM: r.vm_word = {i_imm[15:0], 10'b0, OP_SYS};
      OPC_REG: begin
        case (f7)
          F7_BASE:   op = base_ops[f3];
          F7_ALT:    op = alt_ops[f3];
          F7_MULDIV: op = muldiv_ops[f3];
          default:   op = OP_LB;
        endcase
        r.vm_word = {11'b0, rd, rs2, rs1, op};
      end
      OPC_AUIPC:  r.vm_word = {w[31:12], 1'b0, rd, OP_UPC};
      OPC_LUI:    r.vm_word = {w[31:12], 1'b0, rd, OP_LUI};
      OPC_JAL:    r.vm_word = {j_imm[20:0], rd, OP_JAL};
      default:    r.invalid_opcode = 1'b1;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("mismatch in %s at result %0d: got %h, expected %h",
             what, result_idx, got, want);
  endtask

  always @(posedge clk) begin : watch
    recoded_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        due_q.push_back(recode_instr(in_ch.instr_word, in_ch.end_of_block));
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          report_mismatch("result with nothing due", out_ch.vm_word, '0);
        end else begin
          want = due_q.pop_front();
          if (out_ch.vm_word !== want.vm_word)
            report_mismatch("vm_word", out_ch.vm_word, want.vm_word);
          if (out_ch.invalid_opcode !== want.invalid_opcode)
            report_mismatch("invalid_opcode", {31'b0, out_ch.invalid_opcode},
                            {31'b0, want.invalid_opcode});
          if (out_ch.end_of_block_out !== want.end_of_block)
            report_mismatch("end_of_block_out", {31'b0, out_ch.end_of_block_out},
                            {31'b0, want.end_of_block});
        end
        result_idx++;
      end
    end
    results_due <= due_q.size();
  end

endmodule

[dv/rv32im_to_vm_instruction_recoder_top_tb.sv]
`timescale 1ns / 1ps

module rv32im_to_vm_instruction_recoder_top_tb;
  import rvrec_pkg::*;

  // funct3 values used by the directed words
  localparam logic [2:0] F3_ZERO     = 3'd0;  // lb, sb, beq, add/sub
  localparam logic [2:0] F3_SHL      = 3'd1;  // sll, no alt form
  localparam logic [2:0] F3_WORD     = 3'd2;  // lw, sw; reserved for branches
  localparam logic [2:0] F3_LD_RSVD  = 3'd3;  // no load with this funct3
  localparam logic [2:0] F3_SHR      = 3'd5;  // srl/sra group
  localparam logic [2:0] F3_ALL_ONES = 3'd7;  // andi, bgeu, remu; reserved for stores
  // a major opcode the block does not know (misc-mem)
  localparam logic [6:0] OPC_UNLISTED = 7'h0F;

  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 60000;

  logic clk;
  logic rst_n;
  int   cycles;
  int   fail_count;
  int   results_due;
  int   hold_left;      // receiver hold-off, counted down by the receiver process
  bit   sender_gaps;
  bit   receiver_gaps;

  rvrec_in_if  in_ch ();
  rvrec_out_if out_ch ();

  rv32im_to_vm_instruction_recoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rvrec_recode_checker recode_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // directed words: every major opcode, immediate extremes, unmatched funct codes,
  // shift-right selection by bit 30 only, ignored funct3 and register fields
  logic [31:0] directed_instrs [25] = '{
    32'h0000_0000,                                              // unknown opcode, all zero
    32'hFFFF_FFFF,                                              // unknown opcode, all ones
    {12'h800, 5'd31, F3_WORD, 5'd31, OPC_LOAD},                 // lw, most negative imm
    {12'h7FF, 5'd0, F3_LD_RSVD, 5'd1, OPC_LOAD},                // unmatched load funct3
    {7'h7F, 5'd31, 5'd5, F3_SHR, 5'd9, OPC_OPIMM},              // srai, all funct7 bits set
    {7'h5F, 5'd3, 5'd7, F3_SHR, 5'd2, OPC_OPIMM},               // srli, only bit 30 clear
    {12'hFFF, 5'd31, F3_ALL_ONES, 5'd31, OPC_OPIMM},            // andi, imm -1
    {7'h40, 5'd31, 5'd31, F3_WORD, 5'd0, OPC_STORE},            // sw, most negative imm
    {7'h3F, 5'd0, 5'd1, F3_ZERO, 5'd31, OPC_STORE},             // sb, largest imm
    {7'h15, 5'd9, 5'd4, F3_ALL_ONES, 5'd12, OPC_STORE},         // unmatched store funct3
    {1'b1, 6'h00, 5'd2, 5'd3, F3_ZERO, 4'h0, 1'b0, OPC_BRANCH}, // beq, most negative offset
    {1'b0, 6'h3F, 5'd31, 5'd31, F3_ALL_ONES, 4'hF, 1'b1, OPC_BRANCH}, // bgeu, largest
    {1'b0, 6'h2A, 5'd6, 5'd8, F3_WORD, 4'h5, 1'b1, OPC_BRANCH}, // unmatched branch funct3
    {12'hFFF, 5'd17, F3_ALL_ONES, 5'd31, OPC_JALR},             // jalr, funct3 ignored
    {12'h800, 5'd31, F3_ALL_ONES, 5'd31, OPC_SYSTEM},           // system, regs dropped
    {12'h7FF, 5'd0, F3_ZERO, 5'd0, OPC_SYSTEM},                 // system, largest imm
    {F7_ALT, 5'd31, 5'd0, F3_ZERO, 5'd31, OPC_REG},             // sub
    {F7_ALT, 5'd1, 5'd30, F3_SHR, 5'd15, OPC_REG},              // sra
    {F7_ALT, 5'd7, 5'd7, F3_SHL, 5'd7, OPC_REG},                // unmatched alt funct3
    {F7_MULDIV, 5'd31, 5'd31, F3_ALL_ONES, 5'd31, OPC_REG},     // remu
    {7'h7F, 5'd10, 5'd11, F3_ZERO, 5'd12, OPC_REG},             // unknown funct7
    {20'hFFFFF, 5'd31, OPC_LUI},                                // lui, all upper bits
    {20'h80000, 5'd0, OPC_AUIPC},                               // auipc, sign bit only
    {1'b1, 10'h000, 1'b0, 8'h00, 5'd31, OPC_JAL},               // jal, most negative
    {25'h1FF_FFFF, OPC_UNLISTED}                                // unlisted opcode
  };

  logic [6:0] major_ops [10] = '{OPC_LOAD, OPC_OPIMM, OPC_AUIPC, OPC_STORE, OPC_REG,
                                 OPC_LUI, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};
  logic [6:0] reg_f7s [3] = '{F7_BASE, F7_MULDIV, F7_ALT};

  // mostly well-formed words with random content, some raw noise
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    int          pick;
    w    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick >= 10) begin
      w[6:0] = major_ops[$urandom_range(0, 9)];
      // keep most register-register words on a real funct7
      if (w[6:0] == OPC_REG && pick >= 25) w[31:25] = reg_f7s[$urandom_range(0, 2)];
    end
    return w;
  endfunction

  // offer one item, with random gaps before it, and wait until it is taken
  task automatic send_instr(input logic [31:0] w, input logic eob);
    while (sender_gaps && $urandom_range(0, 99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.instr_word   <= w;
    in_ch.end_of_block <= eob;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until the checker has nothing left due
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on total cycles
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(receiver_gaps && $urandom_range(0, 99) < 24);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.instr_word   = '0;
    in_ch.end_of_block = 1'b0;
    hold_left          = 0;
    sender_gaps        = 1'b1;
    receiver_gaps      = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, end-of-block flagged on a couple of words
    for (int k = 0; k < 25; k++)
      send_instr(directed_instrs[k], k == 5 || k == 24);
    // sender pause until every result is back
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // long receiver hold-off while items keep coming, so the pipe fills and stalls
      if (i == 300) hold_left = 80;
      // a long stretch with no gaps on either side
      if (i == 600) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end
      if (i == 950) begin
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
      end
      if (i == 1200) wait_drained();
      send_instr(random_instr(), $urandom_range(0, 15) == 0);
    end

    wait_drained();
    // keep clocking before the verdict to catch any stray result
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
